### rtl/core/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;
    localparam int CHAR_W = 8;
    localparam int FUNC_W = 2;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7F;

    localparam int TAB_STEP = 4;

    // Blank cell written by the clearing pass after reset.
    localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CHAR_W-1:0] ch;
        logic [LOC_W-1:0]  cell_address;
    } req_t;

    typedef struct packed {
        logic [LOC_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
    } rsp_t;

    // Command from the sequencer to the cursor unit.
    typedef struct packed {
        logic              put;
        logic              home;
        logic [CHAR_W-1:0] ch;
    } cur_cmd_t;

    // Status from the cursor unit to the sequencer.
    typedef struct packed {
        logic             printable;
        logic             scroll;
        logic [LOC_W-1:0] location;
    } cur_stat_t;

endpackage

`default_nettype wire

### rtl/core/tcw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/tcw_cursor.sv
// Cursor column and row registers with the control-character update rules.
`default_nettype none

module tcw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int ADDR_W  = 11
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tcw_pkg::cur_cmd_t  cmd,
    output tcw_pkg::cur_stat_t      stat,
    output logic [ADDR_W-1:0]       cell_index
);

    localparam int CW = tcw_pkg::COL_W + 1;
    localparam int RW = tcw_pkg::ROW_W + 1;

    logic [tcw_pkg::COL_W-1:0] col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]             col_w;
    logic [RW-1:0]             row_w;
    logic                      printable;
    logic                      scroll;
    logic [31:0]               linear;

    assign printable = (cmd.ch >= tcw_pkg::CH_SPACE) && (cmd.ch <= tcw_pkg::CH_PRINT_HI);

    always_comb
    begin
        col_w  = {1'b0, col_reg};
        row_w  = {1'b0, row_reg};
        scroll = 1'b0;
        priority if (cmd.ch == tcw_pkg::CH_BACKSPACE)
        begin
            if (col_reg != '0)
            begin
                col_w = col_w - CW'(1);
            end
        end
        else if (cmd.ch == tcw_pkg::CH_TAB)
        begin
            col_w = (col_w + CW'(tcw_pkg::TAB_STEP)) & ~CW'(tcw_pkg::TAB_STEP - 1);
        end
        else if (cmd.ch == tcw_pkg::CH_RETURN)
        begin
            col_w = '0;
        end
        else if (cmd.ch == tcw_pkg::CH_LINEFEED)
        begin
            col_w = '0;
            row_w = row_w + RW'(1);
        end
        else if (printable)
        begin
            col_w = col_w + CW'(1);
        end
        else
        begin
            col_w = {1'b0, col_reg};
        end
        // Wrap past the last column, then scroll past the last row.
        if (col_w >= CW'(COLUMNS))
        begin
            col_w = '0;
            row_w = row_w + RW'(1);
        end
        if (row_w >= RW'(ROWS))
        begin
            row_w  = RW'(ROWS - 1);
            scroll = 1'b1;
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.home)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.put)
        begin
            col_next = col_w[tcw_pkg::COL_W-1:0];
            row_next = row_w[tcw_pkg::ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign linear = 32'(row_reg) * 32'(COLUMNS) + 32'(col_reg);

    assign stat.printable = printable;
    assign stat.scroll    = scroll;
    assign stat.location  = linear[tcw_pkg::LOC_W-1:0];
    assign cell_index     = linear[ADDR_W-1:0];

endmodule

`default_nettype wire

### rtl/core/text_console_writer.sv
// Top level of the text console writer: sequencer around the screen store.
//
//  channel  direction  payload                            handshake
//  req      in         tcw_pkg::req_t (func, ch, addr)    req_valid / req_ready
//  rsp      out        tcw_pkg::rsp_t (cursor, cell)      rsp_valid / rsp_ready
//  cfg      in         attribute byte                     cfg_valid / cfg_ready
//
// A printable or control character, an off-screen read or an unused code goes
// from idle straight to the done state and an on-screen read passes a read state;
// a scroll sweeps the single RAM port pair, and a clear writes every cell.
// After reset a clearing pass writes COLUMNS*ROWS blank cells with req_ready
// low; configuration writes are taken throughout.
// One request is worked on at a time; a finished response waits in the output
// register while the next request is accepted and processed.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire tcw_pkg::req_t                 req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output tcw_pkg::rsp_t                      rsp,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_attribute
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCROLL = 6'b000100,
        ST_FILL   = 6'b001000,
        ST_READ   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             sweep_reg, sweep_next;
    logic                         pend_reg, pend_next;
    logic [tcw_pkg::CELL_W-1:0]   data_reg, data_next;
    logic [tcw_pkg::ATTR_W-1:0]   attr_reg;
    logic                         rsp_valid_reg, rsp_valid_next;
    tcw_pkg::rsp_t                rsp_reg, rsp_next;

    tcw_pkg::cur_cmd_t            cur_cmd;
    tcw_pkg::cur_stat_t           cur_stat;
    logic [ADDR_W-1:0]            cur_index;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]   ram_rdata;

    logic                         accept;
    logic                         rsp_free;
    logic                         read_in_range;
    logic [31:0]                  req_addr_ext;
    logic [CNT_W-1:0]             scroll_waddr;

    assign req_ready     = (state_reg == ST_IDLE);
    assign accept        = req_valid && req_ready;
    assign rsp_free      = !rsp_valid_reg || rsp_ready;
    assign req_addr_ext  = 32'(req.cell_address);
    assign read_in_range = req_addr_ext < 32'(CELL_COUNT);
    // The write lands one row above the cell read in the cycle before.
    assign scroll_waddr  = sweep_reg - CNT_W'(COLUMNS + 1);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= tcw_pkg::ATTR_RESET;
        end
        else if (cfg_valid)
        begin
            attr_reg <= cfg_attribute;
        end
    end

    always_comb
    begin
        cur_cmd.put  = accept && (req.func == tcw_pkg::FUNC_PUT);
        cur_cmd.home = accept && (req.func == tcw_pkg::FUNC_CLEAR);
        cur_cmd.ch   = req.ch;
    end

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_cursor (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cur_cmd),
        .stat       (cur_stat),
        .cell_index (cur_index)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        pend_next      = pend_reg;
        data_next      = data_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = sweep_reg[ADDR_W-1:0];
        ram_wdata      = {attr_reg, tcw_pkg::CH_SPACE};
        ram_raddr      = sweep_reg[ADDR_W-1:0];

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = tcw_pkg::BLANK_RESET;
                if (sweep_reg == CNT_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                sweep_next = sweep_reg + CNT_W'(1);
            end
            ST_IDLE:
            begin
                ram_raddr = req_addr_ext[ADDR_W-1:0];
                if (accept)
                begin
                    data_next  = '0;
                    state_next = ST_DONE;
                    if (req.func == tcw_pkg::FUNC_PUT)
                    begin
                        ram_we    = cur_stat.printable;
                        ram_waddr = cur_index;
                        ram_wdata = {attr_reg, req.ch};
                        if (cur_stat.scroll)
                        begin
                            state_next = ST_SCROLL;
                            sweep_next = CNT_W'(COLUMNS);
                            pend_next  = 1'b0;
                        end
                    end
                    else if (req.func == tcw_pkg::FUNC_CLEAR)
                    begin
                        state_next = ST_FILL;
                        sweep_next = '0;
                    end
                    else if ((req.func == tcw_pkg::FUNC_READ) && read_in_range)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SCROLL:
            begin
                ram_we    = pend_reg;
                ram_waddr = scroll_waddr[ADDR_W-1:0];
                ram_wdata = ram_rdata;
                if (sweep_reg != CNT_W'(CELL_COUNT))
                begin
                    sweep_next = sweep_reg + CNT_W'(1);
                    pend_next  = 1'b1;
                end
                else
                begin
                    state_next = ST_FILL;
                    sweep_next = CNT_W'(CELL_COUNT - COLUMNS);
                    pend_next  = 1'b0;
                end
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
                if (sweep_reg == CNT_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_DONE;
                end
                sweep_next = sweep_reg + CNT_W'(1);
            end
            ST_READ:
            begin
                data_next  = ram_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.cursor_pos = cur_stat.location;
                    rsp_next.cell_data  = data_reg;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

### rtl/core/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_ready,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_ready,
    input wire tcw_pkg::rsp_t              rsp
);

    localparam int CELL_COUNT = COLUMNS * ROWS;

    logic       req_acc;
    logic       rsp_acc;
    logic [1:0] open_reg, open_next;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        open_next = open_reg;
        if (req_acc && !rsp_acc)
        begin
            open_next = open_reg + 2'd1;
        end
        else if (!req_acc && rsp_acc)
        begin
            open_next = open_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    // Every response belongs to a request that has not yet been answered.
    a_rsp_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (open_reg != 2'd0))
        else $error("response without an open request");

    // One request in work and one response waiting at most.
    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= 2'd2)
        else $error("too many open requests");

    // The engine takes one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("request accepted while one is in work");

    // The reported cursor always lies on the screen.
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((CELL_COUNT > 2048) || (32'(rsp.cursor_pos) < 32'(CELL_COUNT))))
        else $error("cursor location off screen");

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp)
);

`default_nettype wire

### tb/sv/tcw_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class that predicts and checks the text console writer's responses.
package tcw_scoreboard_pkg;

    import tcw_pkg::*;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;

    // The fourth function code is unused; the block must treat it as a no-op.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    class console_scoreboard;

        logic [CELL_W-1:0] screen [SCREEN_CELLS];
        int                column;
        int                row;
        logic [ATTR_W-1:0] attribute;
        rsp_t              awaited_responses [$];
        int                errors;

        function new();
            attribute = ATTR_RESET;
            column    = 0;
            row       = 0;
            errors    = 0;
            blank_from(0);
        endfunction

        function void blank_from(int first);
            int i;
            for (i = first; i < SCREEN_CELLS; i++)
                screen[i] = {attribute, CH_SPACE};
        endfunction

        function void note_attribute(logic [ATTR_W-1:0] value);
            attribute = value;
        endfunction

        function int cursor_now();
            return row * SCREEN_COLUMNS + column;
        endfunction

        function int pending();
            return awaited_responses.size();
        endfunction

        function void put_character(logic [CHAR_W-1:0] ch);
            int i;
            if (ch == CH_BACKSPACE)
            begin
                // Backspace at the left margin leaves the cursor where it is.
                if (column > 0)
                    column--;
            end
            else if (ch == CH_TAB)
                column = (column + TAB_STEP) & ~(TAB_STEP - 1);
            else if (ch == CH_RETURN)
                column = 0;
            else if (ch == CH_LINEFEED)
            begin
                column = 0;
                row++;
            end
            else if (ch >= CH_SPACE && ch <= CH_PRINT_HI)
            begin
                screen[row * SCREEN_COLUMNS + column] = {attribute, ch};
                column++;
            end
            if (column >= SCREEN_COLUMNS)
            begin
                column = 0;
                row++;
            end
            if (row >= SCREEN_ROWS)
            begin
                for (i = 0; i + SCREEN_COLUMNS < SCREEN_CELLS; i++)
                    screen[i] = screen[i + SCREEN_COLUMNS];
                blank_from(SCREEN_CELLS - SCREEN_COLUMNS);
                row = SCREEN_ROWS - 1;
            end
        endfunction

        function void note_request(req_t r);
            rsp_t want;
            want.cell_data = '0;
            case (r.func)
                FUNC_PUT:
                    put_character(r.ch);
                FUNC_CLEAR:
                begin
                    blank_from(0);
                    column = 0;
                    row    = 0;
                end
                FUNC_READ:
                    if (r.cell_address < SCREEN_CELLS)
                        want.cell_data = screen[r.cell_address];
                default:
                    ;
            endcase
            want.cursor_pos = LOC_W'(cursor_now());
            awaited_responses.push_back(want);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (awaited_responses.size() == 0)
            begin
                errors++;
                $display("%0t: response with no request outstanding: cursor %0d cell %h",
                         $time, got.cursor_pos, got.cell_data);
                return;
            end
            want = awaited_responses.pop_front();
            if (got.cursor_pos !== want.cursor_pos)
            begin
                errors++;
                $display("%0t: cursor_pos expected %0d actual %0d",
                         $time, want.cursor_pos, got.cursor_pos);
            end
            if (got.cell_data !== want.cell_data)
            begin
                errors++;
                $display("%0t: cell_data expected %h actual %h",
                         $time, want.cell_data, got.cell_data);
            end
        endfunction

    endclass

endpackage

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench driving the text console writer with directed and random requests.
module testbench;

    import tcw_pkg::*;
    import tcw_scoreboard_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_t                rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [ATTR_W-1:0]   cfg_attribute;

    console_scoreboard   sb = new();

    int                  sender_idle_pct;
    int                  receiver_stall_pct;
    int                  hold_requests;

    text_console_writer #(
        .COLUMNS (SCREEN_COLUMNS),
        .ROWS    (SCREEN_ROWS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_attribute (cfg_attribute)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #120000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic req_t make_req(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                                      logic [LOC_W-1:0] addr);
        req_t r;
        r.func         = func;
        r.ch           = ch;
        r.cell_address = addr;
        return r;
    endfunction

    // Mostly text with line breaks so that the cursor reaches the bottom row and
    // scrolls; clears are kept rare since each one restarts that climb.
    function automatic req_t random_request();
        req_t r;
        int   pick;
        int   sub;
        int   loc;
        r.func         = FUNC_PUT;
        r.ch           = CHAR_W'($urandom);
        r.cell_address = LOC_W'($urandom);
        pick           = $urandom_range(0, 999);
        sub            = $urandom_range(0, 99);
        if (pick < 4)
            r.func = FUNC_CLEAR;
        else if (pick < 24)
            r.func = FUNC_UNUSED;
        else if (pick < 170)
        begin
            r.func = FUNC_READ;
            if (sub < 50)
            begin
                loc = sb.cursor_now() - $urandom_range(0, 160);
                if (loc < 0)
                    loc = 0;
                r.cell_address = LOC_W'(loc);
            end
            else if (sub < 85)
                r.cell_address = LOC_W'($urandom_range(0, SCREEN_CELLS - 1));
            else
                r.cell_address = LOC_W'($urandom_range(SCREEN_CELLS, (1 << LOC_W) - 1));
        end
        else if (sub < 58)
            r.ch = CHAR_W'($urandom_range(CH_SPACE, CH_PRINT_HI));
        else if (sub < 70)
            r.ch = CH_LINEFEED;
        else if (sub < 76)
            r.ch = CH_BACKSPACE;
        else if (sub < 82)
            r.ch = CH_TAB;
        else if (sub < 85)
            r.ch = CH_RETURN;
        else if (sub < 91)
            r.ch = CHAR_W'($urandom_range(0, CH_SPACE - 1));
        else
            r.ch = CHAR_W'($urandom_range(CH_PRINT_HI + 1, (1 << CHAR_W) - 1));
        return r;
    endfunction

    task automatic send_req(input req_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        cfg_attribute <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.note_attribute(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_responses();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int seen;
        int hold_left;
        seen      = 0;
        hold_left = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != seen)
            begin
                seen      = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    initial
    begin
        int                phase;
        int                n;
        logic [ATTR_W-1:0] value;
        rst_n              = 1'b0;
        req_valid          = 1'b0;
        req                = '0;
        cfg_valid          = 1'b0;
        cfg_attribute      = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_requests      = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed requests under the reset attribute.
        send_req(make_req(FUNC_READ, 8'h00, 11'd0));
        send_req(make_req(FUNC_READ, 8'hFF, LOC_W'(SCREEN_CELLS - 1)));
        send_req(make_req(FUNC_READ, 8'h00, 11'h7FF));
        send_req(make_req(FUNC_PUT, 8'h41, 11'd0));
        send_req(make_req(FUNC_PUT, CH_SPACE, 11'd0));
        send_req(make_req(FUNC_PUT, CH_PRINT_HI, 11'h7FF));
        send_req(make_req(FUNC_PUT, 8'h1F, 11'd0));
        send_req(make_req(FUNC_PUT, 8'h80, 11'd0));
        send_req(make_req(FUNC_PUT, 8'hFF, 11'd0));
        send_req(make_req(FUNC_PUT, 8'h00, 11'd0));
        repeat (4) send_req(make_req(FUNC_PUT, CH_BACKSPACE, 11'd0));
        send_req(make_req(FUNC_PUT, CH_TAB, 11'd0));
        send_req(make_req(FUNC_PUT, CH_TAB, 11'd0));
        send_req(make_req(FUNC_PUT, 8'h78, 11'd0));
        send_req(make_req(FUNC_PUT, CH_TAB, 11'd0));
        send_req(make_req(FUNC_PUT, CH_RETURN, 11'd0));
        send_req(make_req(FUNC_PUT, CH_LINEFEED, 11'd0));
        send_req(make_req(FUNC_UNUSED, 8'hAA, 11'd5));
        send_req(make_req(FUNC_READ, 8'h00, 11'd0));
        send_req(make_req(FUNC_READ, 8'h00, 11'd8));
        send_req(make_req(FUNC_CLEAR, 8'h55, 11'h555));
        send_req(make_req(FUNC_READ, 8'h00, 11'd0));
        @(negedge clk);
        req_valid <= 1'b0;

        for (phase = 0; phase < 8; phase++)
        begin
            wait_for_responses();
            case (phase)
                0:       value = 8'hFF;
                1:       value = 8'h00;
                7:       value = ATTR_RESET;
                default: value = ATTR_W'($urandom);
            endcase
            write_attribute(value);
            sender_idle_pct    = (phase % 4 == 1) ? 47 : (phase % 4 == 3) ? 16 : 0;
            receiver_stall_pct = (phase % 4 == 2) ? 47 : (phase % 4 == 3) ? 16 : 0;
            // A long hold-off on the response side fills the block and stalls requests.
            if (phase == 2 || phase == 4)
                hold_requests = hold_requests + 1;
            for (n = 0; n < 144; n++)
                send_req(random_request());
            @(negedge clk);
            req_valid <= 1'b0;
        end

        wait_for_responses();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
